@@ design/dcto_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcto_pkg: shared types and constants
// Node count, index widths and the control and status records passed
// between the sequencer and its engines.
// ----------------------------------------------------------------------------
package dcto_pkg;

  localparam int NODES   = 8;
  localparam int NODE_W  = $clog2(NODES);
  localparam int DEPTH_W = $clog2(NODES + 1);
  localparam int FIELD_W = 4;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef logic [NODES-1:0]   row_t;
  typedef logic [NODE_W-1:0]  idx_t;
  typedef logic [DEPTH_W-1:0] cnt_t;
  typedef logic [FIELD_W-1:0] field_t;

  typedef struct packed {
    logic start;
    logic clear;
  } eng_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic flag;
  } eng_stat_t;

endpackage

@@ design/dcto_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcto_if: valid/ready channels
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface dcto_in_if;
  import dcto_pkg::*;

  logic   valid;
  logic   ready;
  logic   cmd;
  field_t src_node;
  field_t dst_node;

  modport source (output valid, output cmd, output src_node, output dst_node,
                  input ready);
  modport sink (input valid, input cmd, input src_node, input dst_node,
                output ready);
endinterface

interface dcto_out_if;
  import dcto_pkg::*;

  logic   valid;
  logic   ready;
  field_t node;
  logic   cycle_found;
  logic   last;

  modport source (output valid, output node, output cycle_found, output last,
                  input ready);
  modport sink (input valid, input node, input cycle_found, input last,
                output ready);
endinterface

@@ design/dcto_closure.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcto_closure: reachability closure engine
// Copies the adjacency rows, then runs a pivot-by-pivot closure with one
// row OR per cycle and flags any node that reaches itself.
// ----------------------------------------------------------------------------
module dcto_closure (
  input  logic               clk,
  input  logic               rst_n,
  input  dcto_pkg::eng_ctrl_t ctrl,
  input  dcto_pkg::row_t     adj_rdata,
  output dcto_pkg::idx_t     adj_raddr,
  output dcto_pkg::eng_stat_t stat
);
  import dcto_pkg::*;

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_COPY  = 2'd1;
  localparam logic [1:0] C_PIVOT = 2'd2;
  localparam logic [1:0] C_ROW   = 2'd3;

  localparam idx_t IDX_LAST = idx_t'(NODES - 1);

  logic [1:0] state_r, state_nxt;
  idx_t       i_r, i_nxt;
  idx_t       k_r, k_nxt;
  logic       flag_r, flag_nxt;
  logic       done_r, done_nxt;
  row_t       krow_r;
  row_t       cm_r [NODES];

  idx_t cm_addr;
  row_t cm_rdata;
  row_t new_row;

  assign cm_addr   = (state_r == C_PIVOT) ? k_r : i_r;
  assign cm_rdata  = cm_r[cm_addr];
  assign new_row   = cm_rdata[k_r] ? (cm_rdata | krow_r) : cm_rdata;
  assign adj_raddr = i_r;

  assign stat.busy = (state_r != C_IDLE);
  assign stat.done = done_r;
  assign stat.flag = flag_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    flag_nxt  = flag_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (ctrl.start) begin
          state_nxt = C_COPY;
          i_nxt     = '0;
          k_nxt     = '0;
          flag_nxt  = 1'b0;
        end
      end
      C_COPY: begin
        i_nxt = i_r + idx_t'(1);
        if (i_r == IDX_LAST) begin
          state_nxt = C_PIVOT;
          i_nxt     = '0;
        end
      end
      C_PIVOT: begin
        state_nxt = C_ROW;
      end
      C_ROW: begin
        i_nxt = i_r + idx_t'(1);
        if (k_r == IDX_LAST && new_row[i_r]) begin
          flag_nxt = 1'b1;
        end
        if (i_r == IDX_LAST) begin
          i_nxt = '0;
          if (k_r == IDX_LAST) begin
            state_nxt = C_IDLE;
            done_nxt  = 1'b1;
          end else begin
            k_nxt     = k_r + idx_t'(1);
            state_nxt = C_PIVOT;
          end
        end
      end
      default: state_nxt = C_IDLE;
    endcase
    if (ctrl.clear) begin
      state_nxt = C_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      i_r     <= '0;
      k_r     <= '0;
      flag_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      flag_r  <= flag_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_COPY) begin
      cm_r[i_r] <= adj_rdata;
    end else if (state_r == C_ROW) begin
      cm_r[i_r] <= new_row;
    end
    if (state_r == C_PIVOT) begin
      krow_r <= cm_rdata;
    end
  end

endmodule

@@ design/dcto_walk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcto_walk: depth-first walk engine
// One push or pop per cycle while stepping on an explicit stack; post-order is
// collected in the order store, which the sequencer reads back for output.
// ----------------------------------------------------------------------------
module dcto_walk (
  input  logic               clk,
  input  logic               rst_n,
  input  dcto_pkg::eng_ctrl_t ctrl,
  input  dcto_pkg::row_t     adj_rdata,
  output dcto_pkg::idx_t     adj_raddr,
  input  dcto_pkg::idx_t     ord_raddr,
  output dcto_pkg::idx_t     ord_rdata,
  output dcto_pkg::cnt_t     ord_count,
  output dcto_pkg::eng_stat_t stat
);
  import dcto_pkg::*;

  localparam logic [1:0] W_IDLE = 2'd0;
  localparam logic [1:0] W_ROOT = 2'd1;
  localparam logic [1:0] W_STEP = 2'd2;

  localparam cnt_t CNT_FULL = cnt_t'(NODES);
  localparam cnt_t CNT_ONE  = cnt_t'(1);

  logic [1:0] state_r, state_nxt;
  row_t       visited_r, visited_nxt;
  cnt_t       depth_r, depth_nxt;
  cnt_t       cnt_r, cnt_nxt;
  idx_t       root_r, root_nxt;
  logic       done_r, done_nxt;
  idx_t       stack_r [NODES];
  idx_t       order_r [NODES];

  cnt_t depth_m1;
  idx_t top;
  row_t cand;
  idx_t hi_idx;
  logic hi_found;
  logic push_en;
  logic pop_en;
  logic root_en;

  assign depth_m1  = depth_r - CNT_ONE;
  assign top       = stack_r[depth_m1[NODE_W-1:0]];
  assign adj_raddr = top;
  assign cand      = adj_rdata & ~visited_r;

  always_comb begin
    hi_idx   = '0;
    hi_found = 1'b0;
    for (int b = 0; b < NODES; b++) begin
      if (cand[b]) begin
        hi_idx   = idx_t'(b);
        hi_found = 1'b1;
      end
    end
  end

  assign push_en = (state_r == W_STEP) && hi_found && (depth_r < CNT_FULL);
  assign pop_en  = (state_r == W_STEP) && !push_en;
  assign root_en = (state_r == W_ROOT) && !visited_r[root_r];

  assign ord_rdata = order_r[ord_raddr];
  assign ord_count = cnt_r;

  assign stat.busy = (state_r != W_IDLE);
  assign stat.done = done_r;
  assign stat.flag = 1'b0;

  always_comb begin
    state_nxt   = state_r;
    visited_nxt = visited_r;
    depth_nxt   = depth_r;
    cnt_nxt     = cnt_r;
    root_nxt    = root_r;
    done_nxt    = 1'b0;
    unique case (state_r)
      W_IDLE: begin
        if (ctrl.start) begin
          state_nxt   = W_ROOT;
          visited_nxt = '0;
          depth_nxt   = '0;
          cnt_nxt     = '0;
          root_nxt    = idx_t'(NODES - 1);
        end
      end
      W_ROOT: begin
        if (root_en) begin
          visited_nxt[root_r] = 1'b1;
          depth_nxt           = CNT_ONE;
          state_nxt           = W_STEP;
        end else if (root_r == '0) begin
          state_nxt = W_IDLE;
          done_nxt  = 1'b1;
        end else begin
          root_nxt = root_r - idx_t'(1);
        end
      end
      W_STEP: begin
        if (push_en) begin
          visited_nxt[hi_idx] = 1'b1;
          depth_nxt           = depth_r + CNT_ONE;
        end else begin
          depth_nxt = depth_m1;
          if (cnt_r < CNT_FULL) begin
            cnt_nxt = cnt_r + CNT_ONE;
          end
          if (depth_r == CNT_ONE) begin
            if (root_r == '0) begin
              state_nxt = W_IDLE;
              done_nxt  = 1'b1;
            end else begin
              root_nxt  = root_r - idx_t'(1);
              state_nxt = W_ROOT;
            end
          end
        end
      end
      default: state_nxt = W_IDLE;
    endcase
    if (ctrl.clear) begin
      state_nxt = W_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= W_IDLE;
      visited_r <= '0;
      depth_r   <= '0;
      cnt_r     <= '0;
      root_r    <= '0;
      done_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      visited_r <= visited_nxt;
      depth_r   <= depth_nxt;
      cnt_r     <= cnt_nxt;
      root_r    <= root_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (root_en) begin
      stack_r[0] <= root_r;
    end
    if (push_en) begin
      stack_r[depth_r[NODE_W-1:0]] <= hi_idx;
    end
    if (pop_en && cnt_r < CNT_FULL) begin
      order_r[cnt_r[NODE_W-1:0]] <= top;
    end
  end

endmodule

@@ design/dag_cycle_check_topo_order.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_cycle_check_topo_order: cycle check and topological order
// Edge commands build an adjacency matrix; a solve command checks for a cycle
// and, if there is none, streams the nodes in reverse depth-first post-order.
// ----------------------------------------------------------------------------
// An edge transfer gives no result; edges with a node of 0 or above the node
// count are dropped. A solve transfer holds the command channel while the
// closure engine copies the matrix rows and runs the closure (one pivot load
// and one row OR per row for each pivot), the walk engine, when no cycle is
// found, makes its root probes, pushes and pops, and the result stage emits
// its results, and longer while the result channel stalls. Results leave at
// one per cycle while the result channel is ready, from an output register:
// one cycle-flag result if any node reaches itself, otherwise every node
// once, the final one marked last. The graph is kept across solves until
// reset.
module dag_cycle_check_topo_order (
  input  logic       clk,
  input  logic       rst_n,
  dcto_in_if.sink    in_ch,
  dcto_out_if.source out_ch
);
  import dcto_pkg::*;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_CLOSE = 3'd1;
  localparam logic [2:0] M_CYC   = 3'd2;
  localparam logic [2:0] M_WALK  = 3'd3;
  localparam logic [2:0] M_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  idx_t       emit_r, emit_nxt;
  logic       out_valid_r, out_valid_nxt;
  field_t     node_r, node_nxt;
  logic       cyc_r, cyc_nxt;
  logic       last_r, last_nxt;
  row_t       adj_r [NODES];

  eng_ctrl_t cl_ctrl, wk_ctrl;
  eng_stat_t cl_stat, wk_stat;
  idx_t      cl_addr, wk_addr, adj_raddr;
  row_t      adj_rdata;
  idx_t      ord_rdata;
  cnt_t      ord_count;

  logic in_xfer;
  logic edge_ok;
  logic out_free;
  idx_t src_idx, dst_idx;

  assign in_ch.ready = (state_r == M_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign edge_ok     = (in_ch.src_node != '0) && (32'(in_ch.src_node) <= NODES) &&
                       (in_ch.dst_node != '0) && (32'(in_ch.dst_node) <= NODES);
  assign src_idx     = idx_t'(in_ch.src_node - field_t'(1));
  assign dst_idx     = idx_t'(in_ch.dst_node - field_t'(1));
  assign out_free    = !out_valid_r || out_ch.ready;

  assign adj_raddr = cl_stat.busy ? cl_addr : wk_addr;
  assign adj_rdata = adj_r[adj_raddr];

  assign cl_ctrl.start = in_xfer && (in_ch.cmd == CMD_SOLVE);
  assign cl_ctrl.clear = 1'b0;
  assign wk_ctrl.start = (state_r == M_CLOSE) && cl_stat.done && !cl_stat.flag;
  assign wk_ctrl.clear = 1'b0;

  dcto_closure u_closure (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (cl_ctrl),
    .adj_rdata (adj_rdata),
    .adj_raddr (cl_addr),
    .stat      (cl_stat)
  );

  dcto_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (wk_ctrl),
    .adj_rdata (adj_rdata),
    .adj_raddr (wk_addr),
    .ord_raddr (emit_r),
    .ord_rdata (ord_rdata),
    .ord_count (ord_count),
    .stat      (wk_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    node_nxt      = node_r;
    cyc_nxt       = cyc_r;
    last_nxt      = last_r;
    unique case (state_r)
      M_IDLE: begin
        if (cl_ctrl.start) begin
          state_nxt = M_CLOSE;
        end
      end
      M_CLOSE: begin
        if (cl_stat.done) begin
          state_nxt = cl_stat.flag ? M_CYC : M_WALK;
        end
      end
      M_CYC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          node_nxt      = '0;
          cyc_nxt       = 1'b1;
          last_nxt      = 1'b1;
          state_nxt     = M_IDLE;
        end
      end
      M_WALK: begin
        if (wk_stat.done) begin
          emit_nxt  = idx_t'(ord_count - cnt_t'(1));
          state_nxt = M_EMIT;
        end
      end
      M_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          node_nxt      = field_t'({1'b0, ord_rdata} + (NODE_W + 1)'(1));
          cyc_nxt       = 1'b0;
          last_nxt      = (emit_r == '0);
          if (emit_r == '0) begin
            state_nxt = M_IDLE;
          end else begin
            emit_nxt = emit_r - idx_t'(1);
          end
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= M_IDLE;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < NODES; r++) begin
        adj_r[r] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_xfer && in_ch.cmd == CMD_EDGE && edge_ok) begin
        adj_r[src_idx][dst_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    cyc_r  <= cyc_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.node        = node_r;
  assign out_ch.cycle_found = cyc_r;
  assign out_ch.last        = last_r;

endmodule
